// ===== rtl/ipdi_pkg.sv =====
// shared types, codes and reset constants of the interpolated profile double integrator
package ipdi_pkg;

   localparam int TABLE_DEPTH_DEF  = 2048;
   localparam int MAX_SUBSTEPS_DEF = 256;

   localparam logic [16:0] DT_ONE = 17'd65536;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_STEP  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [2:0] CSR_STEPS_PER_SECOND = 3'd0;
   localparam logic [2:0] CSR_STEP_FRACTION    = 3'd1;
   localparam logic [2:0] CSR_FINAL_SECOND     = 3'd2;
   localparam logic [2:0] CSR_WINDOW_START     = 3'd3;
   localparam logic [2:0] CSR_WINDOW_END       = 3'd4;
   localparam logic [2:0] CSR_TOLERANCE        = 3'd5;

   localparam logic [8:0]  RST_STEPS_PER_SECOND = 9'd1;
   localparam logic [16:0] RST_STEP_FRACTION    = 17'd65536;
   localparam logic [10:0] RST_FINAL_SECOND     = 11'd1800;
   localparam logic [10:0] RST_WINDOW_START     = 11'd600;
   localparam logic [10:0] RST_WINDOW_END       = 11'd800;
   localparam logic [62:0] RST_TOLERANCE        = 63'd1677722;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD1,
      ST_INTERP,
      ST_ACCEL,
      ST_VEL,
      ST_POS_LO,
      ST_POS_HI,
      ST_POS_SUM,
      ST_POS,
      ST_DIFF,
      ST_OUT
   } ipdi_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_TAKE_A0,
      OP_INTERP,
      OP_ACCEL,
      OP_VEL,
      OP_POS_LO,
      OP_POS_HI,
      OP_POS_SUM,
      OP_POS
   } ipdi_op_type;

   typedef struct packed {
      ipdi_op_type op;
      logic [16:0] dt;
      logic [16:0] fr;
   } ipdi_ctl_type;

endpackage

// ===== rtl/ipdi_ram.sv =====
// generic single write, single read port ram with registered read data
module ipdi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ipdi_axis.sv =====
// one profile datapath: interpolation, velocity and position integration on a shared multiplier
module ipdi_axis (
   input  logic                  clock,
   input  logic                  reset,
   input  ipdi_pkg::ipdi_ctl_type ctl,
   input  logic [31:0]           rd_data,
   output logic signed [63:0]    vel,
   output logic signed [63:0]    pos
);

   localparam logic [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
   localparam logic [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

   logic signed [31:0] a0_ff, a0_in;
   logic signed [50:0] prod_ff, prod_in;
   logic [48:0]        plo_ff, plo_in;
   logic signed [63:0] mdt_ff, mdt_in;
   logic signed [63:0] vel_ff, vel_in;
   logic signed [63:0] pos_ff, pos_in;

   logic signed [32:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [50:0] mul_p;
   logic signed [34:0] interp_ofs;
   logic signed [31:0] accel;
   logic signed [42:0] vel_inc;
   logic [82:0]        pos_full;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return a[63] ? SAT_MIN : SAT_MAX;
      end
      return s;
   endfunction

   assign interp_ofs = prod_ff[50:16];
   assign accel      = a0_ff + interp_ofs[31:0];
   assign vel_inc    = prod_ff[50:8];
   assign pos_full   = {prod_ff, 32'b0} + {34'b0, plo_ff};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctl.op)
         ipdi_pkg::OP_INTERP: begin
            mul_a = {rd_data[31], rd_data} - {a0_ff[31], a0_ff};
            mul_b = {1'b0, ctl.fr};
         end
         ipdi_pkg::OP_ACCEL: begin
            mul_a = {accel[31], accel};
            mul_b = {1'b0, ctl.dt};
         end
         ipdi_pkg::OP_POS_LO: begin
            mul_a = {1'b0, vel_ff[31:0]};
            mul_b = {1'b0, ctl.dt};
         end
         ipdi_pkg::OP_POS_HI: begin
            mul_a = {vel_ff[63], vel_ff[63:32]};
            mul_b = {1'b0, ctl.dt};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      a0_in   = a0_ff;
      prod_in = prod_ff;
      plo_in  = plo_ff;
      mdt_in  = mdt_ff;
      vel_in  = vel_ff;
      pos_in  = pos_ff;
      case (ctl.op)
         ipdi_pkg::OP_CLEAR: begin
            vel_in = '0;
            pos_in = '0;
         end
         ipdi_pkg::OP_TAKE_A0: a0_in = rd_data;
         ipdi_pkg::OP_INTERP:  prod_in = mul_p;
         ipdi_pkg::OP_ACCEL:   prod_in = mul_p;
         ipdi_pkg::OP_VEL:     vel_in = sat_add(vel_ff, {{21{vel_inc[42]}}, vel_inc});
         ipdi_pkg::OP_POS_LO:  prod_in = mul_p;
         ipdi_pkg::OP_POS_HI: begin
            plo_in  = prod_ff[48:0];
            prod_in = mul_p;
         end
         ipdi_pkg::OP_POS_SUM: mdt_in = pos_full[79:16];
         ipdi_pkg::OP_POS:     pos_in = sat_add(pos_ff, mdt_ff);
         default: begin
            a0_in = a0_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a0_ff   <= a0_in;
      prod_ff <= prod_in;
      plo_ff  <= plo_in;
      mdt_ff  <= mdt_in;
      if (reset) begin
         vel_ff <= '0;
         pos_ff <= '0;
      end else begin
         vel_ff <= vel_in;
         pos_ff <= pos_in;
      end
   end

   assign vel = vel_ff;
   assign pos = pos_ff;

endmodule

// ===== rtl/interpolated_profile_double_integrator.sv =====
// top level of the interpolated profile double integrator
//
// req channel: one command per transfer. load writes both acceleration samples at
// entry_index into the two table rams, clear zeroes time and the four integrators,
// step advances both profiles by one substep. loads, clears and ignored commands
// give no result.
// a step reads the sample pair at floor(t) and its neighbour from the tables, then
// runs the sequencer through interpolation, velocity, position and the match test on
// one shared multiplier per profile. the result is written into the rsp register as the
// sequencer leaves its output state, and the next command is taken after that, so a new
// step cannot start before the last one is through; the multiplier shared across the
// dependent products sets that limit.
// the rsp register holds one result; while it waits, loads and clears still
// transfer and a following step runs until its result is ready, then waits for
// rsp_stall to drop before it is written.
// csr writes are always ready and should only come while no step is in flight.
// reset is synchronous and restores the csr defaults, zero time and integrators;
// the table contents are not cleared and must be loaded before use.
module interpolated_profile_double_integrator #(
   parameter int TABLE_DEPTH  = ipdi_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_SUBSTEPS = ipdi_pkg::MAX_SUBSTEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [10:0]        req_entry_index,
   input  logic signed [31:0] req_linear_accel,
   input  logic signed [31:0] req_nonlinear_accel,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [10:0]        rsp_whole_second,
   output logic [7:0]         rsp_substep,
   output logic signed [63:0] rsp_linear_velocity,
   output logic signed [63:0] rsp_linear_position,
   output logic signed [63:0] rsp_nonlinear_velocity,
   output logic signed [63:0] rsp_nonlinear_position,
   output logic               rsp_positions_match,
   output logic               rsp_run_finished,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int SW = (MAX_SUBSTEPS > 1) ? $clog2(MAX_SUBSTEPS) : 1;
   localparam int FW = SW + 17;

   // configuration
   logic [8:0]  csr_sps_ff;
   logic [16:0] csr_frac_ff;
   logic [10:0] csr_final_ff;
   logic [10:0] csr_wstart_ff;
   logic [10:0] csr_wend_ff;
   logic [62:0] csr_tol_ff;

   // time and run state
   logic [10:0]   sec_ff, sec_in;
   logic [SW-1:0] sub_ff, sub_in;
   logic          done_ff, done_in;

   // per step registers
   logic [10:0]   step_sec_ff;
   logic [7:0]    step_sub_ff;
   logic          fin_ff;
   logic          win_ok_ff;
   logic [16:0]   dt_ff;
   logic [16:0]   fr_ff;
   logic [AW-1:0] i1_ff;
   logic [64:0]   diff_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [10:0]        rsp_sec_ff;
   logic [7:0]         rsp_sub_ff;
   logic signed [63:0] rsp_lv_ff, rsp_lp_ff, rsp_nv_ff, rsp_np_ff;
   logic               rsp_match_ff, rsp_fin_ff;

   ipdi_pkg::ipdi_state_type state_ff, state_in;
   ipdi_pkg::ipdi_op_type    op;
   ipdi_pkg::ipdi_ctl_type   ctl;

   logic          req_accept;
   logic          step_go;
   logic          out_free;
   logic          out_load;
   logic [16:0]   sps_eff;
   logic [16:0]   dt_eff;
   logic [16:0]   sub_inc;
   logic          sub_wrap;
   logic [FW-1:0] fr_prod;
   logic [16:0]   fr_eff;
   logic [AW-1:0] i0;
   logic [AW-1:0] i1;
   logic [31:0]   i1_wide;
   logic          step_fin;
   logic          step_win;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [31:0]   lin_rd, nl_rd;
   logic signed [63:0] lin_vel, lin_pos, nl_vel, nl_pos;
   logic [65:0]   diff_ext;
   logic [65:0]   tol_ext;
   logic [65:0]   diff_sum;
   logic          pos_match;

   assign req_accept = req_valid && !req_stall;
   assign step_go    = req_accept && req_command == ipdi_pkg::CMD_STEP && !done_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_sps_ff    <= ipdi_pkg::RST_STEPS_PER_SECOND;
         csr_frac_ff   <= ipdi_pkg::RST_STEP_FRACTION;
         csr_final_ff  <= ipdi_pkg::RST_FINAL_SECOND;
         csr_wstart_ff <= ipdi_pkg::RST_WINDOW_START;
         csr_wend_ff   <= ipdi_pkg::RST_WINDOW_END;
         csr_tol_ff    <= ipdi_pkg::RST_TOLERANCE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ipdi_pkg::CSR_STEPS_PER_SECOND: csr_sps_ff    <= csr_data[8:0];
            ipdi_pkg::CSR_STEP_FRACTION:    csr_frac_ff   <= csr_data[16:0];
            ipdi_pkg::CSR_FINAL_SECOND:     csr_final_ff  <= csr_data[10:0];
            ipdi_pkg::CSR_WINDOW_START:     csr_wstart_ff <= csr_data[10:0];
            ipdi_pkg::CSR_WINDOW_END:       csr_wend_ff   <= csr_data[10:0];
            ipdi_pkg::CSR_TOLERANCE:        csr_tol_ff    <= csr_data[62:0];
            default: begin
               csr_tol_ff <= csr_tol_ff;
            end
         endcase
      end
   end

   // clamped step parameters and table indexes of the current time
   always_comb begin
      if (csr_sps_ff == '0) begin
         sps_eff = 17'd1;
      end else if (32'(csr_sps_ff) > MAX_SUBSTEPS) begin
         sps_eff = 17'(MAX_SUBSTEPS);
      end else begin
         sps_eff = 17'(csr_sps_ff);
      end

      if (csr_frac_ff == '0) begin
         dt_eff = 17'd1;
      end else if (csr_frac_ff > ipdi_pkg::DT_ONE) begin
         dt_eff = ipdi_pkg::DT_ONE;
      end else begin
         dt_eff = csr_frac_ff;
      end

      fr_prod = FW'(sub_ff) * FW'(dt_eff);
      if (fr_prod > FW'(ipdi_pkg::DT_ONE)) begin
         fr_eff = ipdi_pkg::DT_ONE;
      end else begin
         fr_eff = fr_prod[16:0];
      end

      if (32'(sec_ff) < TABLE_DEPTH) begin
         i0 = AW'(sec_ff);
      end else begin
         i0 = AW'(TABLE_DEPTH - 1);
      end
      i1_wide = 32'(i0) + 32'd1;
      if (32'(i0) >= 32'(csr_final_ff) || i1_wide >= TABLE_DEPTH) begin
         i1 = i0;
      end else begin
         i1 = AW'(i1_wide);
      end

      sub_inc  = 17'(sub_ff) + 17'd1;
      sub_wrap = sub_inc >= sps_eff;
      step_fin = sub_ff == '0 && sec_ff >= csr_final_ff;
      step_win = sec_ff >= csr_wstart_ff &&
                 (sec_ff < csr_wend_ff || (sec_ff == csr_wend_ff && sub_ff == '0));
   end

   always_comb begin
      sec_in  = sec_ff;
      sub_in  = sub_ff;
      done_in = done_ff;
      if (req_accept && req_command == ipdi_pkg::CMD_CLEAR) begin
         sec_in  = '0;
         sub_in  = '0;
         done_in = 1'b0;
      end else if (step_go) begin
         if (step_fin) begin
            done_in = 1'b1;
         end
         if (sub_wrap) begin
            sub_in = '0;
            sec_in = sec_ff + 11'd1;
         end else begin
            sub_in = SW'(sub_inc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff  <= '0;
         sub_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         sec_ff  <= sec_in;
         sub_ff  <= sub_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         step_sec_ff <= sec_ff;
         step_sub_ff <= 8'(sub_ff);
         fin_ff      <= step_fin;
         win_ok_ff   <= step_win;
         dt_ff       <= dt_eff;
         fr_ff       <= fr_eff;
         i1_ff       <= i1;
      end
      if (state_ff == ipdi_pkg::ST_DIFF) begin
         diff_ff <= {lin_pos[63], lin_pos} - {nl_pos[63], nl_pos};
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ipdi_pkg::ST_IDLE:    if (step_go) state_in = ipdi_pkg::ST_RD1;
         ipdi_pkg::ST_RD1:     state_in = ipdi_pkg::ST_INTERP;
         ipdi_pkg::ST_INTERP:  state_in = ipdi_pkg::ST_ACCEL;
         ipdi_pkg::ST_ACCEL:   state_in = ipdi_pkg::ST_VEL;
         ipdi_pkg::ST_VEL:     state_in = ipdi_pkg::ST_POS_LO;
         ipdi_pkg::ST_POS_LO:  state_in = ipdi_pkg::ST_POS_HI;
         ipdi_pkg::ST_POS_HI:  state_in = ipdi_pkg::ST_POS_SUM;
         ipdi_pkg::ST_POS_SUM: state_in = ipdi_pkg::ST_POS;
         ipdi_pkg::ST_POS:     state_in = ipdi_pkg::ST_DIFF;
         ipdi_pkg::ST_DIFF:    state_in = ipdi_pkg::ST_OUT;
         ipdi_pkg::ST_OUT:     if (out_free) state_in = ipdi_pkg::ST_IDLE;
         default:              state_in = ipdi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rd_addr   = i1_ff;
      out_load  = 1'b0;
      op        = ipdi_pkg::OP_NONE;
      case (state_ff)
         ipdi_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            rd_addr   = i0;
            if (req_accept && req_command == ipdi_pkg::CMD_CLEAR) begin
               op = ipdi_pkg::OP_CLEAR;
            end
         end
         ipdi_pkg::ST_RD1:     op = ipdi_pkg::OP_TAKE_A0;
         ipdi_pkg::ST_INTERP:  op = ipdi_pkg::OP_INTERP;
         ipdi_pkg::ST_ACCEL:   op = ipdi_pkg::OP_ACCEL;
         ipdi_pkg::ST_VEL:     op = ipdi_pkg::OP_VEL;
         ipdi_pkg::ST_POS_LO:  op = ipdi_pkg::OP_POS_LO;
         ipdi_pkg::ST_POS_HI:  op = ipdi_pkg::OP_POS_HI;
         ipdi_pkg::ST_POS_SUM: op = ipdi_pkg::OP_POS_SUM;
         ipdi_pkg::ST_POS:     op = ipdi_pkg::OP_POS;
         ipdi_pkg::ST_OUT:     out_load = out_free;
         default: begin
            op = ipdi_pkg::OP_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ipdi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign ctl.op = op;
   assign ctl.dt = dt_ff;
   assign ctl.fr = fr_ff;

   // acceleration tables
   assign wr_en = req_accept && req_command == ipdi_pkg::CMD_LOAD &&
                  32'(req_entry_index) < TABLE_DEPTH;

   ipdi_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_DEPTH)
   ) u_lin_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (req_linear_accel),
      .rd_addr (rd_addr),
      .rd_data (lin_rd)
   );

   ipdi_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_DEPTH)
   ) u_nl_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (req_nonlinear_accel),
      .rd_addr (rd_addr),
      .rd_data (nl_rd)
   );

   ipdi_axis u_lin_axis (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_data (lin_rd),
      .vel     (lin_vel),
      .pos     (lin_pos)
   );

   ipdi_axis u_nl_axis (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_data (nl_rd),
      .vel     (nl_vel),
      .pos     (nl_pos)
   );

   // position match: |diff| < tolerance
   assign diff_ext = {diff_ff[64], diff_ff};
   assign tol_ext  = {3'b0, csr_tol_ff};
   assign diff_sum = diff_ext + tol_ext;
   always_comb begin
      if (!diff_ff[64]) begin
         pos_match = diff_ext < tol_ext;
      end else begin
         pos_match = !diff_sum[65] && diff_sum != '0;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         rsp_sec_ff   <= step_sec_ff;
         rsp_sub_ff   <= step_sub_ff;
         rsp_lv_ff    <= lin_vel;
         rsp_lp_ff    <= lin_pos;
         rsp_nv_ff    <= nl_vel;
         rsp_np_ff    <= nl_pos;
         rsp_match_ff <= win_ok_ff && pos_match;
         rsp_fin_ff   <= fin_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_whole_second       = rsp_sec_ff;
   assign rsp_substep            = rsp_sub_ff;
   assign rsp_linear_velocity    = rsp_lv_ff;
   assign rsp_linear_position    = rsp_lp_ff;
   assign rsp_nonlinear_velocity = rsp_nv_ff;
   assign rsp_nonlinear_position = rsp_np_ff;
   assign rsp_positions_match    = rsp_match_ff;
   assign rsp_run_finished       = rsp_fin_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ipdi_pkg::ST_OUT))
      else $error("result appeared outside the output state");

   a_done_blocks_step: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && done_ff) |=> state_ff == ipdi_pkg::ST_IDLE)
      else $error("step started after the run finished");

   a_seq_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == ipdi_pkg::ST_RD1 |->
         $past(req_valid && !req_stall && req_command == ipdi_pkg::CMD_STEP))
      else $error("sequencer started without a step transfer");

   a_fin_sets_done: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && rsp_fin_ff) |-> done_ff)
      else $error("final step reported without the run marked done");
`endif

endmodule

// ===== verif/interpolated_profile_double_integrator_tb.sv =====
// testbench of the interpolated profile double integrator: stimulus table, random runs, step checks
module interpolated_profile_double_integrator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SIZE    = ipdi_pkg::TABLE_DEPTH_DEF;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 24;
   localparam int END_CYCLES    = 40;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 80;
   localparam int TAIL_STEPS    = 100;

   localparam logic [1:0]  CMD_SPARE    = 2'd3;
   localparam logic [2:0]  CSR_SPARE_LO = 3'd6;
   localparam logic [2:0]  CSR_SPARE_HI = 3'd7;
   localparam logic [63:0] TOL_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [10:0]        whole_second;
      logic [7:0]         substep;
      logic signed [63:0] lin_vel;
      logic signed [63:0] lin_pos;
      logic signed [63:0] nl_vel;
      logic signed [63:0] nl_pos;
      logic               pos_match;
      logic               run_end;
   } step_result_type;

   typedef enum bit {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      logic [1:0]      cmd;
      logic [10:0]     idx;
      logic [31:0]     la;
      logic [31:0]     na;
      logic [2:0]      reg_idx;
      logic [63:0]     reg_val;
      bit              typed;
      step_result_type want;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_command = ipdi_pkg::CMD_LOAD;
   logic [10:0]        req_entry_index = '0;
   logic signed [31:0] req_linear_accel = '0;
   logic signed [31:0] req_nonlinear_accel = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [10:0]        rsp_whole_second;
   logic [7:0]         rsp_substep;
   logic signed [63:0] rsp_linear_velocity;
   logic signed [63:0] rsp_linear_position;
   logic signed [63:0] rsp_nonlinear_velocity;
   logic signed [63:0] rsp_nonlinear_position;
   logic               rsp_positions_match;
   logic               rsp_run_finished;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [63:0]        csr_data = '0;

   // predictor state
   logic [31:0]  lin_samples [TABLE_SIZE];
   logic [31:0]  nl_samples [TABLE_SIZE];
   bit           sample_loaded [TABLE_SIZE];
   logic [10:0]  now_second = '0;
   int unsigned  now_substep = 0;
   longint       lin_vel = 0, lin_pos = 0, nl_vel = 0, nl_pos = 0;
   bit           run_over = 1'b0;
   logic [8:0]   cfg_sps = ipdi_pkg::RST_STEPS_PER_SECOND;
   logic [16:0]  cfg_dt = ipdi_pkg::RST_STEP_FRACTION;
   logic [10:0]  cfg_final = ipdi_pkg::RST_FINAL_SECOND;
   logic [10:0]  cfg_win_lo = ipdi_pkg::RST_WINDOW_START;
   logic [10:0]  cfg_win_hi = ipdi_pkg::RST_WINDOW_END;
   logic [62:0]  cfg_tol = ipdi_pkg::RST_TOLERANCE;

   step_result_type due_results [$];
   stim_row_type    plan [$];
   int              mismatches = 0;
   int              cycle_count = 0;
   int              stall_left = 0;
   bit              idle_on = 1'b1;
   bit              close_mode = 1'b0;

   always #5 clock = ~clock;

   interpolated_profile_double_integrator dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_command            (req_command),
      .req_entry_index        (req_entry_index),
      .req_linear_accel       (req_linear_accel),
      .req_nonlinear_accel    (req_nonlinear_accel),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_whole_second       (rsp_whole_second),
      .rsp_substep            (rsp_substep),
      .rsp_linear_velocity    (rsp_linear_velocity),
      .rsp_linear_position    (rsp_linear_position),
      .rsp_nonlinear_velocity (rsp_nonlinear_velocity),
      .rsp_nonlinear_position (rsp_nonlinear_position),
      .rsp_positions_match    (rsp_positions_match),
      .rsp_run_finished       (rsp_run_finished),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   function automatic longint sat_sum(input longint a, input longint b);
      longint s;
      s = a + b;
      if (a >= 0 && b >= 0 && s < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
      return s;
   endfunction

   // floor(v * dt / 65536) without overflow
   function automatic longint scale_dt(input longint v, input longint dt);
      longint hi, lo;
      hi = v >>> 16;
      lo = v & 64'hFFFF;
      return hi * dt + ((lo * dt) >>> 16);
   endfunction

   function automatic longint lerp(input logic [31:0] s0, input logic [31:0] s1,
         input longint frac);
      longint a0, a1;
      a0 = $signed(s0);
      a1 = $signed(s1);
      return a0 + (((a1 - a0) * frac) >>> 16);
   endfunction

   function automatic void neighbour_pair(output int unsigned i0, output int unsigned i1);
      i0 = now_second;
      i1 = i0 + 1;
      if (i0 >= cfg_final || i1 >= TABLE_SIZE) i1 = i0;
   endfunction

   function automatic bit profile_step(input logic [1:0] cmd, input logic [10:0] idx,
         input logic [31:0] la, input logic [31:0] na, output step_result_type r);
      int unsigned sps, i0, i1;
      longint      dt, frac, al, an;
      logic [63:0] gap;
      bit          in_window;
      r = '0;
      if (cmd == ipdi_pkg::CMD_LOAD) begin
         lin_samples[idx] = la;
         nl_samples[idx] = na;
         sample_loaded[idx] = 1'b1;
         return 1'b0;
      end
      if (cmd == ipdi_pkg::CMD_CLEAR) begin
         now_second = '0;
         now_substep = 0;
         lin_vel = 0;
         lin_pos = 0;
         nl_vel = 0;
         nl_pos = 0;
         run_over = 1'b0;
         return 1'b0;
      end
      if (cmd != ipdi_pkg::CMD_STEP || run_over) return 1'b0;
      sps = (cfg_sps == 0) ? 1 : ((cfg_sps > ipdi_pkg::MAX_SUBSTEPS_DEF) ?
         ipdi_pkg::MAX_SUBSTEPS_DEF : cfg_sps);
      dt = (cfg_dt == 0) ? 1 : ((cfg_dt > ipdi_pkg::DT_ONE) ? ipdi_pkg::DT_ONE : cfg_dt);
      frac = longint'(now_substep) * dt;
      if (frac > 65536) frac = 65536;
      neighbour_pair(i0, i1);
      al = lerp(lin_samples[i0], lin_samples[i1], frac);
      an = lerp(nl_samples[i0], nl_samples[i1], frac);
      lin_vel = sat_sum(lin_vel, (al * dt) >>> 8);
      lin_pos = sat_sum(lin_pos, scale_dt(lin_vel, dt));
      nl_vel = sat_sum(nl_vel, (an * dt) >>> 8);
      nl_pos = sat_sum(nl_pos, scale_dt(nl_vel, dt));
      gap = (lin_pos >= nl_pos) ? lin_pos - nl_pos : nl_pos - lin_pos;
      in_window = now_second >= cfg_win_lo &&
         (now_second < cfg_win_hi || (now_second == cfg_win_hi && now_substep == 0));
      r.whole_second = now_second;
      r.substep = now_substep[7:0];
      r.lin_vel = lin_vel;
      r.lin_pos = lin_pos;
      r.nl_vel = nl_vel;
      r.nl_pos = nl_pos;
      r.pos_match = gap < {1'b0, cfg_tol} && in_window;
      r.run_end = now_substep == 0 && now_second >= cfg_final;
      if (r.run_end) run_over = 1'b1;
      now_substep++;
      if (now_substep >= sps) begin
         now_substep = 0;
         now_second = now_second + 11'd1;
      end
      return 1'b1;
   endfunction

   function automatic logic [31:0] pick_accel();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom();
         default: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      endcase
   endfunction

   function automatic stim_row_type req_row(input logic [1:0] cmd, input logic [10:0] idx,
         input logic [31:0] la, input logic [31:0] na);
      stim_row_type row;
      row = '{kind: ROW_REQ, cmd: cmd, idx: idx, la: la, na: na, reg_idx: '0, reg_val: '0,
              typed: 1'b0, want: '0};
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [2:0] reg_idx, input logic [63:0] val);
      stim_row_type row;
      row = req_row(ipdi_pkg::CMD_LOAD, '0, '0, '0);
      row.kind = ROW_CSR;
      row.reg_idx = reg_idx;
      row.reg_val = val;
      return row;
   endfunction

   function automatic stim_row_type checked_step(input step_result_type want);
      stim_row_type row;
      row = req_row(ipdi_pkg::CMD_STEP, '0, '0, '0);
      row.typed = 1'b1;
      row.want = want;
      return row;
   endfunction

   task automatic push_req(input logic [1:0] cmd, input logic [10:0] idx, input logic [31:0] la,
         input logic [31:0] na, input bit typed, input step_result_type want);
      step_result_type r;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_entry_index <= idx;
      req_linear_accel <= la;
      req_nonlinear_accel <= na;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (profile_step(cmd, idx, la, na, r)) due_results.push_back(typed ? want : r);
   endtask

   task automatic send(input logic [1:0] cmd, input logic [10:0] idx, input logic [31:0] la,
         input logic [31:0] na);
      push_req(cmd, idx, la, na, 1'b0, '0);
   endtask

   task automatic load_entry(input logic [10:0] idx);
      logic [31:0] la, na;
      la = pick_accel();
      na = close_mode ? la + $urandom_range(0, 64) - 32'd32 : pick_accel();
      send(ipdi_pkg::CMD_LOAD, idx, la, na);
   endtask

   // never let a step read a sample that has not been loaded
   task automatic take_step();
      int unsigned i0, i1;
      if (!run_over) begin
         neighbour_pair(i0, i1);
         if (!sample_loaded[i0]) load_entry(i0[10:0]);
         if (!sample_loaded[i1]) load_entry(i1[10:0]);
      end
      send(ipdi_pkg::CMD_STEP, 11'($urandom()), $urandom(), $urandom());
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      logic [63:0] mask, data;
      case (idx)
         ipdi_pkg::CSR_STEPS_PER_SECOND: mask = 64'h1FF;
         ipdi_pkg::CSR_STEP_FRACTION:    mask = 64'h1_FFFF;
         ipdi_pkg::CSR_FINAL_SECOND:     mask = 64'h7FF;
         ipdi_pkg::CSR_WINDOW_START:     mask = 64'h7FF;
         ipdi_pkg::CSR_WINDOW_END:       mask = 64'h7FF;
         ipdi_pkg::CSR_TOLERANCE:        mask = TOL_MAX;
         default:                        mask = '0;
      endcase
      data = (value & mask) | ({$urandom(), $urandom()} & ~mask);
      case (idx)
         ipdi_pkg::CSR_STEPS_PER_SECOND: cfg_sps = data[8:0];
         ipdi_pkg::CSR_STEP_FRACTION:    cfg_dt = data[16:0];
         ipdi_pkg::CSR_FINAL_SECOND:     cfg_final = data[10:0];
         ipdi_pkg::CSR_WINDOW_START:     cfg_win_lo = data[10:0];
         ipdi_pkg::CSR_WINDOW_END:       cfg_win_hi = data[10:0];
         ipdi_pkg::CSR_TOLERANCE:        cfg_tol = data[62:0];
         default: ;
      endcase
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_result();
      step_result_type want;
      if (due_results.size() == 0) begin
         $error("result transfer with nothing expected, second %0d substep %0d",
            rsp_whole_second, rsp_substep);
         mismatches++;
      end else begin
         want = due_results.pop_front();
         cmp_field("whole_second", want.whole_second, rsp_whole_second);
         cmp_field("substep", want.substep, rsp_substep);
         cmp_field("linear_velocity", want.lin_vel, rsp_linear_velocity);
         cmp_field("linear_position", want.lin_pos, rsp_linear_position);
         cmp_field("nonlinear_velocity", want.nl_vel, rsp_nonlinear_velocity);
         cmp_field("nonlinear_position", want.nl_pos, rsp_nonlinear_position);
         cmp_field("positions_match", want.pos_match, rsp_positions_match);
         cmp_field("run_finished", want.run_end, rsp_run_finished);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_result();
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
      rsp_stall <= (stall_left > 0);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("interpolated_profile_double_integrator test failed");
         $finish;
      end
   end

   initial begin : main
      step_result_type want;
      int              counted, roll;
      int unsigned     eff, sps_v, dt_v, fin_v, lo_v, hi_v, cap;
      logic [63:0]     tol_v;

      // directed table
      want = '0;
      plan.push_back(req_row(ipdi_pkg::CMD_LOAD, 11'd0, 32'h0, 32'h0));
      plan.push_back(req_row(ipdi_pkg::CMD_LOAD, 11'd1, 32'h0, 32'h0));
      plan.push_back(checked_step(want));
      plan.push_back(req_row(CMD_SPARE, 11'd2047, 32'h7FFF_FFFF, 32'h8000_0000));
      plan.push_back(req_row(ipdi_pkg::CMD_CLEAR, 11'd0, 32'h0, 32'h0));
      plan.push_back(req_row(ipdi_pkg::CMD_LOAD, 11'd0, 32'h7FFF_FFFF, 32'h8000_0000));
      want.lin_vel = 64'h0000_007F_FFFF_FF00;
      want.lin_pos = 64'h0000_007F_FFFF_FF00;
      want.nl_vel = 64'hFFFF_FF80_0000_0000;
      want.nl_pos = 64'hFFFF_FF80_0000_0000;
      plan.push_back(checked_step(want));
      plan.push_back(req_row(ipdi_pkg::CMD_LOAD, 11'd2047, 32'h8000_0000, 32'h7FFF_FFFF));
      plan.push_back(req_row(ipdi_pkg::CMD_LOAD, 11'd1, 32'h0001_0000, 32'hFFFF_0000));
      plan.push_back(req_row(ipdi_pkg::CMD_LOAD, 11'd2, 32'hFFFF_FFFF, 32'h0000_0001));
      plan.push_back(csr_row(ipdi_pkg::CSR_FINAL_SECOND, 64'd2));
      plan.push_back(csr_row(ipdi_pkg::CSR_STEPS_PER_SECOND, 64'd3));
      plan.push_back(csr_row(ipdi_pkg::CSR_WINDOW_START, 64'd0));
      plan.push_back(csr_row(ipdi_pkg::CSR_WINDOW_END, 64'd1));
      plan.push_back(csr_row(ipdi_pkg::CSR_TOLERANCE, TOL_MAX));
      plan.push_back(req_row(ipdi_pkg::CMD_CLEAR, 11'd0, 32'h0, 32'h0));
      // third substep clamps the interpolation fraction, last one finishes the run
      repeat (7) begin
         plan.push_back(req_row(ipdi_pkg::CMD_STEP, 11'h555, 32'hAAAA_AAAA, 32'h5555_5555));
      end
      plan.push_back(req_row(ipdi_pkg::CMD_STEP, 11'h2AA, 32'h5555_5555, 32'hAAAA_AAAA));
      plan.push_back(req_row(ipdi_pkg::CMD_CLEAR, 11'd0, 32'h0, 32'h0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            drain();
            csr_write(plan[i].reg_idx, plan[i].reg_val);
            csr_valid <= 1'b0;
         end else begin
            push_req(plan[i].cmd, plan[i].idx, plan[i].la, plan[i].na, plan[i].typed,
               plan[i].want);
         end
      end

      // random runs over a spread of register settings
      for (int p = 0; p < PHASES; p++) begin
         idle_on = $urandom_range(0, 4) != 0;
         close_mode = (p % 2) != 0;
         drain();
         case (p % 5)
            0: sps_v = 0;
            1: sps_v = 1;
            2: sps_v = $urandom_range(2, 255);
            3: sps_v = 256;
            default: sps_v = $urandom_range(257, 511);
         endcase
         eff = (sps_v == 0) ? 1 : ((sps_v > 256) ? 256 : sps_v);
         case ((p + 2) % 5)
            0: dt_v = 65536 / eff;
            1: dt_v = 0;
            2: dt_v = $urandom_range(1, 65535);
            3: dt_v = 65536;
            default: dt_v = $urandom_range(65537, 131071);
         endcase
         if (p == 1) fin_v = 2047;
         else if (p % 4 == 3) fin_v = 0;
         else fin_v = $urandom_range(1, 1 + 60 / eff);
         cap = (fin_v + 1 > 2047) ? 2047 : fin_v + 1;
         if (p == 2) begin
            lo_v = 0;
            hi_v = 2047;
         end else if (p == 7) begin
            lo_v = 2047;
            hi_v = 0;
         end else begin
            lo_v = $urandom_range(0, fin_v);
            hi_v = $urandom_range(lo_v, cap);
         end
         case (p % 4)
            0: tol_v = 0;
            1: tol_v = TOL_MAX;
            2: tol_v = ipdi_pkg::RST_TOLERANCE;
            default: tol_v = {$urandom(), $urandom()} >> $urandom_range(1, 63);
         endcase
         csr_write(ipdi_pkg::CSR_STEPS_PER_SECOND, sps_v);
         csr_write(ipdi_pkg::CSR_STEP_FRACTION, dt_v);
         csr_write(ipdi_pkg::CSR_FINAL_SECOND, fin_v);
         csr_write(ipdi_pkg::CSR_WINDOW_START, lo_v);
         csr_write(ipdi_pkg::CSR_WINDOW_END, hi_v);
         csr_write(ipdi_pkg::CSR_TOLERANCE, tol_v);
         if (p == 0) begin
            csr_write(CSR_SPARE_LO, {$urandom(), $urandom()});
            csr_write(CSR_SPARE_HI, {$urandom(), $urandom()});
         end
         csr_valid <= 1'b0;
         send(ipdi_pkg::CMD_CLEAR, 11'($urandom()), $urandom(), $urandom());
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (run_over) begin
               if (roll < 25) begin
                  send(ipdi_pkg::CMD_STEP, 11'($urandom()), $urandom(), $urandom());
               end else begin
                  send(ipdi_pkg::CMD_CLEAR, 11'($urandom()), $urandom(), $urandom());
                  counted++;
               end
            end else if (roll < 70) begin
               take_step();
               counted++;
            end else if (roll < 85) begin
               if (roll < 78 && now_second < 2045) begin
                  load_entry(11'(now_second + $urandom_range(0, 2)));
               end else begin
                  load_entry(11'($urandom()));
               end
               counted++;
            end else if (roll < 90) begin
               send(ipdi_pkg::CMD_CLEAR, 11'($urandom()), $urandom(), $urandom());
               counted++;
            end else begin
               send(CMD_SPARE, 11'($urandom()), $urandom(), $urandom());
            end
         end
      end

      // closing run at full acceleration and full rate, no idling
      idle_on = 1'b0;
      drain();
      csr_write(ipdi_pkg::CSR_STEPS_PER_SECOND, 256);
      csr_write(ipdi_pkg::CSR_STEP_FRACTION, 65536);
      csr_write(ipdi_pkg::CSR_FINAL_SECOND, 2047);
      csr_write(ipdi_pkg::CSR_WINDOW_START, 0);
      csr_write(ipdi_pkg::CSR_WINDOW_END, 2047);
      csr_write(ipdi_pkg::CSR_TOLERANCE, TOL_MAX);
      csr_valid <= 1'b0;
      send(ipdi_pkg::CMD_CLEAR, 11'd0, 32'h0, 32'h0);
      for (int k = 0; k < 32; k++) begin
         send(ipdi_pkg::CMD_LOAD, k[10:0], 32'h7FFF_FFFF, 32'h8000_0000);
      end
      repeat (TAIL_STEPS) take_step();

      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("interpolated_profile_double_integrator test passed");
      end else begin
         $display("interpolated_profile_double_integrator test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ipdi_pkg.sv
rtl/ipdi_ram.sv
rtl/ipdi_axis.sv
rtl/interpolated_profile_double_integrator.sv
verif/interpolated_profile_double_integrator_tb.sv
